// ===== rtl/dog_keypoint_detector_top_macros.svh =====
// Assertion helpers used by the detector top module.
`ifndef DOG_KEYPOINT_DETECTOR_TOP_MACROS_SVH
`define DOG_KEYPOINT_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, checked on aclk outside reset.
`define DKD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dkd assertion failed");

// Next-cycle implication, checked on aclk outside reset.
`define DKD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dkd assertion failed");

`endif

// ===== rtl/dkd_pkg.sv =====
`timescale 1ns / 1ps
package dkd_pkg;
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int IMG_W_BITS   = 11;
    localparam int THRESH_BITS  = 15;
    localparam int RATIO_BITS   = 7;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 15;
    localparam int ROW_BITS     = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONTRAST    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATIO       = 2'd2;

    localparam logic [IMG_W_BITS-1:0]  RST_IMAGE_WIDTH = 11'd640;
    localparam logic [THRESH_BITS-1:0] RST_CONTRAST    = 15'd983;
    localparam logic [RATIO_BITS-1:0]  RST_RATIO       = 7'd10;
endpackage

// ===== rtl/dkd_ram.sv =====
`timescale 1ns / 1ps
module dkd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/dog_keypoint_detector_top.sv =====
`timescale 1ns / 1ps
// Steps from input accept to result valid: line store read and window update,
//   compare and differences, multiply, subtract, ratio compare, in that order.
// One item at a time: the single sequencer accepts only when idle, walks the item
//   through the line stores and the Hessian products, and waits on output stalls.
// Reset (aresetn low, synchronous): registers to defaults, counters and window to
//   zero, no result pending; line stores are not cleared.
module dog_keypoint_detector_top
    import dkd_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_layer_below,
    input  logic signed [SAMPLE_BITS-1:0] s_layer_middle,
    input  logic signed [SAMPLE_BITS-1:0] s_layer_above,
    input  logic                          s_start_of_frame,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_window_valid,
    output logic                          m_is_maximum,
    output logic                          m_is_minimum,
    output logic                          m_passed_contrast,
    output logic                          m_passed_edge,
    output logic                          m_keypoint
);
    localparam int SB   = SAMPLE_BITS;
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int MWB  = $clog2(MAX_WIDTH + 1);
    localparam int EW   = (MWB > IMG_W_BITS) ? MWB : IMG_W_BITS;
    localparam int LW   = 3 * SB;
    localparam int DX   = SB + 2;
    localparam int SW   = SB + 3;
    localparam int PW   = 2 * DX;
    localparam int QW   = 2 * SW;
    localparam int DW   = PW + 5;
    localparam int RW   = DW + RATIO_BITS + 1;
    localparam int ABW  = SB + 1;
    localparam int CMPW = ((ABW > THRESH_BITS) ? ABW : THRESH_BITS) + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_HES  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [IMG_W_BITS-1:0]  image_width_reg;
    logic [THRESH_BITS-1:0] contrast_reg;
    logic [RATIO_BITS-1:0]  ratio_reg;

    logic [AW-1:0]       column_count_reg;
    logic [ROW_BITS-1:0] row_count_reg;

    logic signed [SB-1:0] px_reg [3];
    logic [AW-1:0]        col_reg;
    logic                 valid_reg;

    logic signed [SB-1:0] win_reg [3][3][3];

    logic          is_max_reg, is_min_reg, contrast_ok_reg;
    logic signed [DX-1:0] dxx_reg, dyy_reg, dxy_reg;
    logic signed [SW-1:0] s_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic signed [QW-1:0] q_reg;
    logic signed [DW-1:0] det_reg;

    logic [LW-1:0] older_rdata, newer_rdata;
    logic          accept;
    logic [AW-1:0] col_cur, raddr;
    logic [ROW_BITS-1:0] row_cur;
    logic [EW-1:0] eff_w;
    logic          out_room;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_room = !m_valid || m_ready;

    always_comb begin
        if (image_width_reg < IMG_W_BITS'(3)) begin
            eff_w = EW'(3);
        end else if (EW'(image_width_reg) > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(image_width_reg);
        end
    end

    assign col_cur = s_start_of_frame ? '0 : column_count_reg;
    assign row_cur = s_start_of_frame ? '0 : row_count_reg;
    assign raddr   = col_cur;

    dkd_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_older (
        .aclk  (aclk),
        .we    (state_reg == ST_RD),
        .waddr (col_reg),
        .wdata (newer_rdata),
        .raddr (raddr),
        .rdata (older_rdata)
    );

    dkd_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_newer (
        .aclk  (aclk),
        .we    (state_reg == ST_RD),
        .waddr (col_reg),
        .wdata ({px_reg[2], px_reg[1], px_reg[0]}),
        .raddr (raddr),
        .rdata (newer_rdata)
    );

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= RST_IMAGE_WIDTH;
            contrast_reg    <= RST_CONTRAST;
            ratio_reg       <= RST_RATIO;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH: image_width_reg <= cfg_data[IMG_W_BITS-1:0];
                CFG_CONTRAST:    contrast_reg    <= cfg_data[THRESH_BITS-1:0];
                CFG_RATIO:       ratio_reg       <= cfg_data[RATIO_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RD;
            ST_RD:   state_next = ST_HES;
            ST_HES:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_FIN;
            ST_FIN:  if (out_room) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // counters, item latch, window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    for (int l = 0; l < 3; l++) begin
                        win_reg[r][c][l] <= '0;
                    end
                end
            end
        end else begin
            state_reg <= state_next;
            if (accept) begin
                if (EW'(col_cur) + EW'(1) >= eff_w) begin
                    column_count_reg <= '0;
                    if (row_cur != '1) begin
                        row_count_reg <= row_cur + ROW_BITS'(1);
                    end else begin
                        row_count_reg <= row_cur;
                    end
                end else begin
                    column_count_reg <= col_cur + AW'(1);
                    row_count_reg    <= row_cur;
                end
            end
            if (state_reg == ST_RD) begin
                for (int r = 0; r < 3; r++) begin
                    for (int l = 0; l < 3; l++) begin
                        win_reg[r][0][l] <= win_reg[r][1][l];
                        win_reg[r][1][l] <= win_reg[r][2][l];
                    end
                end
                for (int l = 0; l < 3; l++) begin
                    win_reg[0][2][l] <= older_rdata[l*SB +: SB];
                    win_reg[1][2][l] <= newer_rdata[l*SB +: SB];
                    win_reg[2][2][l] <= px_reg[l];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg[0] <= s_layer_below;
            px_reg[1] <= s_layer_middle;
            px_reg[2] <= s_layer_above;
            col_reg   <= col_cur;
            valid_reg <= (row_cur >= ROW_BITS'(2)) && (col_cur >= AW'(2))
                         && (EW'(col_cur) < eff_w);
        end
    end

    // extremum, contrast and Hessian differences from the updated window
    logic                  max_c, min_c, contrast_c;
    logic signed [SB-1:0]  ctr;
    logic [ABW-1:0]        abs_c;
    logic signed [DX-1:0]  dxx_c, dyy_c, dxy_c;

    assign ctr = win_reg[1][1][1];

    always_comb begin
        max_c = 1'b1;
        min_c = 1'b1;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                for (int l = 0; l < 3; l++) begin
                    if (!(r == 1 && c == 1 && l == 1)) begin
                        if (!(ctr > win_reg[r][c][l])) max_c = 1'b0;
                        if (!(ctr < win_reg[r][c][l])) min_c = 1'b0;
                    end
                end
            end
        end
        abs_c = ctr[SB-1] ? ABW'(-ABW'($signed(ctr))) : ABW'($signed(ctr));
        contrast_c = CMPW'(abs_c) >= CMPW'(contrast_reg);
        dxx_c = DX'(win_reg[1][2][1]) + DX'(win_reg[1][0][1]) - (DX'(ctr) <<< 1);
        dyy_c = DX'(win_reg[2][1][1]) + DX'(win_reg[0][1][1]) - (DX'(ctr) <<< 1);
        dxy_c = DX'(win_reg[2][2][1]) + DX'(win_reg[0][0][1])
              - DX'(win_reg[0][2][1]) - DX'(win_reg[2][0][1]);
    end

    logic signed [RW-1:0] rdet_c, tr2_c;
    logic                 edge_c;

    always_comb begin
        rdet_c = RW'(det_reg) * RW'($signed({1'b0, ratio_reg}));
        tr2_c  = RW'(q_reg) <<< 4;
        edge_c = (det_reg > 0) && (tr2_c < rdet_c);
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_HES) begin
            is_max_reg      <= max_c;
            is_min_reg      <= min_c;
            contrast_ok_reg <= contrast_c;
            dxx_reg         <= dxx_c;
            dyy_reg         <= dyy_c;
            dxy_reg         <= dxy_c;
            s_reg           <= SW'(dxx_c) + SW'(dyy_c);
        end
        if (state_reg == ST_MUL) begin
            p1_reg <= PW'(dxx_reg) * PW'(dyy_reg);
            p2_reg <= PW'(dxy_reg) * PW'(dxy_reg);
            q_reg  <= QW'(s_reg) * QW'(s_reg);
        end
        if (state_reg == ST_SUM) begin
            // 16*det in the scale of the published differences
            det_reg <= (DW'(p1_reg) <<< 4) - DW'(p2_reg);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (state_reg == ST_FIN && out_room) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_room) begin
            m_window_valid    <= valid_reg;
            m_is_maximum      <= valid_reg && is_max_reg;
            m_is_minimum      <= valid_reg && is_min_reg;
            m_passed_contrast <= valid_reg && contrast_ok_reg;
            m_passed_edge     <= valid_reg && edge_c;
            m_keypoint        <= valid_reg && (is_max_reg || is_min_reg)
                                 && contrast_ok_reg && edge_c;
        end
    end

`include "dog_keypoint_detector_top_macros.svh"

    `DKD_ASSERT_NEXT(a_accept_reads, accept, state_reg == ST_RD)
    `DKD_ASSERT_NOW(a_not_both, m_valid, !(m_is_maximum && m_is_minimum))
    `DKD_ASSERT_NOW(a_keypoint_valid, m_valid && m_keypoint,
                    m_window_valid && m_passed_contrast && m_passed_edge)
    `DKD_ASSERT_NEXT(a_fin_holds, state_reg == ST_FIN && !out_room, state_reg == ST_FIN)
endmodule
